>>> hw/rtl/sks_pkg.sv
// Shared types and constants of the servo keyframe sequencer.
`default_nettype none
package sks_pkg;
    localparam int Channels = 16;
    localparam int Commands = 32;
    localparam int Joints = 16;
    localparam int ChW = $clog2(Channels);
    localparam int CmdW = $clog2(Commands);
    localparam int JW = $clog2(Joints);
    localparam int EntW = CmdW + JW;

    localparam logic [2:0] ActTick = 3'd0;
    localparam logic [2:0] ActBegin = 3'd1;
    localparam logic [2:0] ActLoad = 3'd2;
    localparam logic [2:0] ActStart = 3'd3;
    localparam logic [2:0] ActDirect = 3'd4;
    localparam logic [2:0] ActKeep = 3'd5;
    localparam logic [2:0] ActStop = 3'd6;

    localparam logic [0:0] CfgTimeout = 1'b0;
    localparam logic [0:0] CfgNeutral = 1'b1;

    localparam logic [12:0] InstrMax = 13'd8191;
    localparam logic [15:0] StepMsMax = 16'd65535;

    // Request to and answer from the shared divider.
    typedef struct packed {
        logic        start;
        logic [22:0] dividend_mag;
        logic        negative;
        logic [9:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [22:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

>>> hw/rtl/sks_divider.sv
// Restoring divider, one quotient bit per cycle, signed result truncated toward zero.
`default_nettype none
module sks_divider
    import sks_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [22:0] r_quo, n_quo;
    logic [9:0]  r_rem, n_rem;
    logic [9:0]  r_div;
    logic        r_neg;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [10:0] trial;
    logic [10:0] shifted;

    always_comb begin
        shifted = {r_rem, r_quo[22]};
        trial   = shifted - {1'b0, r_div};
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo = i_req.dividend_mag;
            n_rem = '0;
            n_cnt = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[10]) begin
                n_rem = trial[9:0];
                n_quo = {r_quo[21:0], 1'b1};
            end else begin
                n_rem = shifted[9:0];
                n_quo = {r_quo[21:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd22) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_neg <= i_req.negative;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_neg ? (23'd0 - r_quo) : r_quo;
endmodule
`default_nettype wire

>>> hw/rtl/servo_keyframe_sequencer.sv
// Top level of the servo keyframe sequencer: sequencer, divider, tables and result register.
//
// Usage. Items arrive on the input channel (i_valid / o_ready): ticks each
// millisecond, plus begin, load joint, start, direct set, keepalive and stop
// instructions. Results leave on the output channel (o_valid / i_ready) as
// PWM writes or one timeout notice; o_last marks the final result of an item.
// Configuration writes (timeout_ms at index 0, neutral_pwm at index 1) use
// their own channel and are always taken.
// Flow: the block takes one item at a time. An item that causes no result
// leaves the input open. A direct set to a real channel or a timeout keeps
// the input closed until its result transfer completes. A tick that runs a
// playback step keeps the input closed while each joint of the command passes
// S_ADV, S_FETCH, S_READ, S_DIV, S_WAIT and S_EMIT; a joint on no real channel
// skips S_DIV and S_WAIT, and the shared 23-bit restoring divider yields one
// quotient bit per cycle.
// A result is held in the output register until the transfer completes; the
// sequencer waits there while the receiver stalls, and nothing is lost.
// Reset clears playback, counters, fill counts and known PWM values (the
// known PWM table has one valid bit per channel). The joint entry memory is
// not cleared; loads must precede use, which the fill counts ensure.
`default_nettype none
module servo_keyframe_sequencer
    import sks_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [4:0]  i_command_slot,
    input  wire logic [3:0]  i_joint_slot,
    input  wire logic [4:0]  i_pin,
    input  wire logic [11:0] i_pwm_value,
    input  wire logic [5:0]  i_command_total,
    input  wire logic [9:0]  i_steps,
    input  wire logic [15:0] i_delay_ms,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_kind,
    output logic [3:0]       o_channel,
    output logic [11:0]      o_pwm,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_ADV   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [12:0] r_timeout;
    logic [11:0] r_neutral;
    logic r_playing;
    logic [CmdW-1:0] r_cmd;
    logic [9:0] r_step;
    logic [5:0] r_in_use;
    logic [9:0] r_step_count;
    logic [15:0] r_step_delay;
    logic [JW:0] r_fill [Commands];
    // One past the last joint of each command that sits on a real channel; 0 if none.
    logic [JW:0] r_lastv [Commands];
    logic [11:0] r_known [Channels];
    logic [Channels-1:0] r_known_vld;
    logic [12:0] r_ms_instr;
    logic [15:0] r_ms_step;
    logic [JW:0] r_j;
    logic [JW:0] r_count;
    logic [4:0] r_mem_ch [Commands*Joints];
    logic [11:0] r_mem_tgt [Commands*Joints];
    logic [4:0] r_rd_ch;
    logic [11:0] r_rd_tgt;
    logic [22:0] r_prod;
    logic [12:0] r_start;
    logic r_out_vld, r_kind, r_last;
    logic [ChW-1:0] r_ch;
    logic [11:0] r_pwm;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic in_xfer, out_xfer;
    logic emit_now;
    logic [12:0] ms_instr_nxt;
    logic [15:0] ms_step_nxt;
    logic [9:0] steps_eff;
    logic final_step;
    logic [ChW-1:0] rd_ch;
    logic [11:0] known_rd, start_v;
    logic signed [13:0] diff;
    logic signed [24:0] prod_full;
    logic signed [14:0] val_s;
    logic [11:0] val_sat;
    logic [EntW-1:0] wr_idx, rd_idx;
    logic [JW:0] j_next;

    assign in_xfer = i_valid && o_ready;
    assign out_xfer = r_out_vld && i_ready;
    assign o_ready = (r_state == S_IDLE) && !r_out_vld;
    assign o_cfg_ready = 1'b1;
    // A joint result enters the output register in the cycle it leaves or while it is empty.
    assign emit_now = (r_state == S_EMIT) && (r_rd_ch < 5'(Channels))
                      && (!r_out_vld || out_xfer);
    // Both millisecond counters saturate.
    assign ms_instr_nxt = (r_ms_instr != InstrMax) ? r_ms_instr + 13'd1 : r_ms_instr;
    assign ms_step_nxt = (r_ms_step != StepMsMax) ? r_ms_step + 16'd1 : r_ms_step;
    assign steps_eff = (r_step_count == 10'd0) ? 10'd1 : r_step_count;
    assign final_step = ({1'b0, r_step} + 11'd1) >= {1'b0, steps_eff};
    assign rd_ch = r_rd_ch[ChW-1:0];
    assign known_rd = r_known_vld[rd_ch] ? r_known[rd_ch] : 12'd0;
    assign start_v = (known_rd != 12'd0) ? known_rd : r_neutral;
    assign diff = $signed({2'b00, r_rd_tgt}) - $signed({2'b00, start_v});
    assign prod_full = diff * $signed({1'b0, r_step + 10'd1});
    assign val_s = $signed({2'b00, r_start}) + $signed(div_rsp.quotient[14:0]);
    assign val_sat = val_s[14] ? 12'd0 : ((val_s > 15'sd4095) ? 12'd4095 : val_s[11:0]);
    assign wr_idx = {i_command_slot[CmdW-1:0], i_joint_slot};
    assign rd_idx = {r_cmd, r_j[JW-1:0]};
    assign j_next = r_j + 1'b1;

    // The product magnitude fits 23 bits; the sign rides separately.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_prod <= prod_full[24] ? 23'(-prod_full) : prod_full[22:0];
            r_start <= {1'b0, start_v};
        end
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.dividend_mag = r_prod;
        div_req.negative = 1'b0;
        div_req.divisor = steps_eff;
        if (r_state == S_DIV) begin
            div_req.start = 1'b1;
        end
    end
    logic r_prod_neg;
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) r_prod_neg <= prod_full[24];
    end
    t_div_req div_req_q;
    always_comb begin
        div_req_q = div_req;
        div_req_q.negative = r_prod_neg;
    end

    sks_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req_q),
        .o_rsp  (div_rsp)
    );

    // Joint entry memory: one write port for loads, one registered read.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_action == ActLoad && {1'b0, i_command_slot} < r_in_use
                && {1'b0, i_joint_slot} == r_fill[i_command_slot[CmdW-1:0]]) begin
            r_mem_ch[wr_idx] <= i_pin;
            r_mem_tgt[wr_idx] <= i_pwm_value;
        end
        if (r_state == S_FETCH) begin
            r_rd_ch <= r_mem_ch[rd_idx];
            r_rd_tgt <= r_mem_tgt[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_timeout <= 13'd4000;
            r_neutral <= 12'd300;
            r_playing <= 1'b0;
            r_cmd <= '0;
            r_step <= '0;
            r_in_use <= '0;
            r_step_count <= 10'd20;
            r_step_delay <= 16'd20;
            for (int i = 0; i < Commands; i++) r_fill[i] <= '0;
            for (int i = 0; i < Commands; i++) r_lastv[i] <= '0;
            r_known_vld <= '0;
            r_ms_instr <= '0;
            r_ms_step <= '0;
            r_out_vld <= 1'b0;
            r_j <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgTimeout: r_timeout <= i_cfg_data;
                    CfgNeutral: r_neutral <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (out_xfer && !emit_now) r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_action == ActBegin || i_action == ActLoad || i_action == ActStart
                                || i_action == ActKeep || i_action == ActStop)
                            r_ms_instr <= '0;
                        case (i_action)
                            ActTick: begin
                                r_ms_instr <= ms_instr_nxt;
                                if (r_playing && ms_instr_nxt > r_timeout) begin
                                    r_playing <= 1'b0;
                                    r_out_vld <= 1'b1;
                                    r_kind <= 1'b1;
                                    r_ch <= '0;
                                    r_pwm <= '0;
                                    r_last <= 1'b1;
                                    r_ms_step <= ms_step_nxt;
                                end else if (r_playing && ms_step_nxt >= r_step_delay) begin
                                    r_ms_step <= '0;
                                    r_j <= '0;
                                    r_count <= ({1'b0, r_cmd} < r_in_use) ? r_fill[r_cmd] : '0;
                                    r_state <= S_ADV;
                                end else begin
                                    r_ms_step <= ms_step_nxt;
                                end
                            end
                            ActBegin: begin
                                r_playing <= 1'b0;
                                r_in_use <= (i_command_total > 6'(Commands)) ? 6'(Commands)
                                            : i_command_total;
                                r_step_count <= i_steps;
                                r_step_delay <= i_delay_ms;
                                for (int i = 0; i < Commands; i++) r_fill[i] <= '0;
                                for (int i = 0; i < Commands; i++) r_lastv[i] <= '0;
                            end
                            ActLoad: begin
                                if ({1'b0, i_command_slot} < r_in_use
                                        && {1'b0, i_joint_slot}
                                           == r_fill[i_command_slot[CmdW-1:0]]) begin
                                    r_fill[i_command_slot[CmdW-1:0]] <= {1'b0, i_joint_slot} + 1'b1;
                                    if (i_pin < 5'(Channels))
                                        r_lastv[i_command_slot[CmdW-1:0]] <=
                                            {1'b0, i_joint_slot} + 1'b1;
                                end
                            end
                            ActStart: begin
                                r_playing <= 1'b1;
                                r_cmd <= '0;
                                r_step <= '0;
                                r_ms_step <= '0;
                            end
                            ActDirect: begin
                                if (i_pin < 5'(Channels)) begin
                                    r_known[i_pin[ChW-1:0]] <= i_pwm_value;
                                    r_known_vld[i_pin[ChW-1:0]] <= 1'b1;
                                    r_out_vld <= 1'b1;
                                    r_kind <= 1'b0;
                                    r_ch <= i_pin[ChW-1:0];
                                    r_pwm <= i_pwm_value;
                                    r_last <= 1'b1;
                                end
                            end
                            ActStop: r_playing <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                // S_ADV checks for another joint, else advances the step and goes idle.
                S_ADV: begin
                    if (r_j < r_count) begin
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_IDLE;
                        if (final_step) begin
                            r_step <= '0;
                            r_cmd <= ({1'b0, r_cmd} + 6'd1 >= r_in_use) ? '0 : r_cmd + 1'b1;
                        end else begin
                            r_step <= r_step + 10'd1;
                        end
                    end
                end
                S_FETCH: r_state <= S_READ;
                S_READ: r_state <= (r_rd_ch < 5'(Channels)) ? S_DIV : S_EMIT;
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (div_rsp.done) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_rd_ch >= 5'(Channels)) begin
                        r_j <= j_next;
                        r_state <= S_ADV;
                    end else if (emit_now) begin
                        r_out_vld <= 1'b1;
                        r_kind <= 1'b0;
                        r_ch <= rd_ch;
                        r_pwm <= val_sat;
                        // Last valid joint: no later joint maps to a real channel.
                        r_last <= (j_next == r_lastv[r_cmd]);
                        if (final_step) begin
                            r_known[rd_ch] <= val_sat;
                            r_known_vld[rd_ch] <= 1'b1;
                        end
                        r_j <= j_next;
                        r_state <= S_ADV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_kind = r_kind;
    assign o_channel = 4'(r_ch);
    assign o_pwm = r_pwm;
    assign o_last = r_last;
endmodule
`default_nettype wire
